FILE: rtl/smsnfp_pkg.sv
// Package for the SMS notification field parser.
// Holds the character codes, field limits, parse stage type and result record.
// No dependencies.
package smsnfp_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned NUM_LIMIT_W = 5;
   localparam int unsigned MSG_LIMIT_W = 8;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUMBER_LIMIT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MESSAGE_LIMIT = 1'b1;

   localparam logic [NUM_LIMIT_W-1:0] NUMBER_LIMIT_RESET  = 5'd12;
   localparam logic [MSG_LIMIT_W-1:0] MESSAGE_LIMIT_RESET = 8'd160;
   localparam logic [DATA_W-1:0]      DATE_LIMIT          = 8'd20;

   localparam logic [DATA_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;

   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BODY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

   // output queue depth, a power of two
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [8:0] {
      ST_WAIT_NUM   = 9'b000000001,
      ST_NUM        = 9'b000000010,
      ST_WAIT_ALIAS = 9'b000000100,
      ST_ALIAS      = 9'b000001000,
      ST_WAIT_DATE  = 9'b000010000,
      ST_DATE       = 9'b000100000,
      ST_WAIT_CR    = 9'b001000000,
      ST_WAIT_LF    = 9'b010000000,
      ST_BODY       = 9'b100000000
   } stage_type;

   typedef struct packed {
      logic [KIND_W-1:0] field_kind;
      logic [DATA_W-1:0] char_position;
      logic [DATA_W-1:0] char_value;
      logic              end_flag;
   } result_type;

endpackage

FILE: rtl/sms_notification_field_parser_unit.sv
// Top level of the SMS notification field parser.
// Parse stage machine, two-byte hold line and a four-entry result queue.
// Depends on smsnfp_pkg.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  req      | in  | tvalid/tready      | tdata = rx_byte, tlast = last_byte
//  rsp      | out | tvalid/tready      | tdata = char_position, char_value;
//           |     |                    | tuser = field_kind, tlast = end_flag
//  csr      | in  | we                 | addr 0 number_limit, addr 1 message_limit
//
// One byte is taken per cycle while req_tready is high; the byte leaving the hold line
// is parsed and its results are registered into the queue. Only a final beat gives two
// results (character, end); the hold line then refills for two beats without results, so
// the queue keeps up. req_tready is low while fewer than two queue entries are free.
// Synchronous reset restores the limits, empties the queue and clears the parser.
module sms_notification_field_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_position, [15:8] char_value
   output logic [1:0]  rsp_tuser,   // [1:0] field_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [smsnfp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [smsnfp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [smsnfp_pkg::NUM_LIMIT_W-1:0] number_limit_ff;
   logic [smsnfp_pkg::MSG_LIMIT_W-1:0] message_limit_ff;

   smsnfp_pkg::stage_type          stage_ff, stage_in;
   logic [smsnfp_pkg::DATA_W-1:0]  index_ff, index_in;
   logic [smsnfp_pkg::DATA_W-1:0]  held_ff [2];
   logic [smsnfp_pkg::DATA_W-1:0]  held_in [2];
   logic [1:0]                     held_count_ff, held_count_in;

   smsnfp_pkg::result_type         queue_ff [smsnfp_pkg::QUEUE_DEPTH];
   logic [smsnfp_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [smsnfp_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [smsnfp_pkg::QCNT_W-1:0]  count_ff, count_in;

   logic                           req_beat, rsp_beat;
   logic [smsnfp_pkg::DATA_W-1:0]  c;
   logic                           parse_en;
   logic                           char_valid;
   smsnfp_pkg::result_type         char_res, end_res;
   logic [smsnfp_pkg::DATA_W-1:0]  p_index;
   smsnfp_pkg::stage_type          p_stage;
   logic [smsnfp_pkg::DATA_W-1:0]  num_lim, msg_lim;
   logic [1:0]                     n_push;
   logic [smsnfp_pkg::QPTR_W-1:0]  wr_ptr_next;

   assign req_tready = (count_ff <= smsnfp_pkg::QCNT_W'(smsnfp_pkg::QUEUE_DEPTH - 2));
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_beat   = rsp_tvalid && rsp_tready;

   assign rsp_tdata = {queue_ff[rd_ptr_ff].char_value, queue_ff[rd_ptr_ff].char_position};
   assign rsp_tuser = queue_ff[rd_ptr_ff].field_kind;
   assign rsp_tlast = queue_ff[rd_ptr_ff].end_flag;

   assign num_lim  = smsnfp_pkg::DATA_W'(number_limit_ff);
   assign msg_lim  = message_limit_ff;
   assign parse_en = (held_count_ff == 2'd2);
   assign c        = held_ff[0];

   // parse the byte leaving the hold line
   always_comb begin
      p_stage    = stage_ff;
      p_index    = index_ff;
      char_valid = 1'b0;
      char_res   = '{field_kind: smsnfp_pkg::KIND_NUMBER, char_position: index_ff,
                     char_value: c, end_flag: 1'b0};
      if (c == smsnfp_pkg::CH_QUOTE) begin
         unique case (stage_ff)
            smsnfp_pkg::ST_WAIT_NUM: begin
               p_stage = smsnfp_pkg::ST_NUM;
               p_index = '0;
            end
            smsnfp_pkg::ST_NUM:        p_stage = smsnfp_pkg::ST_WAIT_ALIAS;
            smsnfp_pkg::ST_WAIT_ALIAS: begin
               p_stage = smsnfp_pkg::ST_ALIAS;
               p_index = '0;
            end
            smsnfp_pkg::ST_ALIAS:      p_stage = smsnfp_pkg::ST_WAIT_DATE;
            smsnfp_pkg::ST_WAIT_DATE: begin
               p_stage = smsnfp_pkg::ST_DATE;
               p_index = '0;
            end
            smsnfp_pkg::ST_DATE:       p_stage = smsnfp_pkg::ST_WAIT_CR;
            default: ;
         endcase
      end else if (c == smsnfp_pkg::CH_CR && stage_ff != smsnfp_pkg::ST_BODY) begin
         if (stage_ff == smsnfp_pkg::ST_WAIT_CR) p_stage = smsnfp_pkg::ST_WAIT_LF;
      end else if (c == smsnfp_pkg::CH_LF && stage_ff != smsnfp_pkg::ST_BODY) begin
         if (stage_ff == smsnfp_pkg::ST_WAIT_LF) begin
            p_stage = smsnfp_pkg::ST_BODY;
            p_index = '0;
         end
      end else if (stage_ff == smsnfp_pkg::ST_NUM && index_ff < num_lim) begin
         char_valid = 1'b1;
         p_index    = index_ff + 8'd1;
      end else if (stage_ff == smsnfp_pkg::ST_DATE && index_ff < smsnfp_pkg::DATE_LIMIT) begin
         p_index = index_ff + 8'd1;
      end else if (stage_ff == smsnfp_pkg::ST_BODY && index_ff < msg_lim) begin
         char_valid          = 1'b1;
         char_res.field_kind = smsnfp_pkg::KIND_BODY;
         p_index             = index_ff + 8'd1;
      end
   end

   assign end_res = '{field_kind: smsnfp_pkg::KIND_END, char_position: '0,
                      char_value: '0, end_flag: 1'b1};

   // next parser state for an accepted beat
   always_comb begin
      stage_in      = stage_ff;
      index_in      = index_ff;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      n_push        = 2'd0;
      if (req_beat) begin
         if (parse_en) begin
            stage_in   = p_stage;
            index_in   = p_index;
            held_in[0] = held_ff[1];
            held_in[1] = req_tdata;
            n_push     = {1'b0, char_valid};
         end else begin
            held_in[held_count_ff[0]] = req_tdata;
            held_count_in             = held_count_ff + 2'd1;
         end
         if (req_tlast) begin
            stage_in      = smsnfp_pkg::ST_WAIT_NUM;
            index_in      = '0;
            held_in[0]    = '0;
            held_in[1]    = '0;
            held_count_in = '0;
            n_push        = n_push + 2'd1;
         end
      end
   end

   assign wr_ptr_next = wr_ptr_ff + smsnfp_pkg::QPTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + smsnfp_pkg::QPTR_W'(n_push);
   assign rd_ptr_in   = rd_ptr_ff + smsnfp_pkg::QPTR_W'(rsp_beat);
   assign count_in    = count_ff + smsnfp_pkg::QCNT_W'(n_push)
                        - smsnfp_pkg::QCNT_W'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         number_limit_ff  <= smsnfp_pkg::NUMBER_LIMIT_RESET;
         message_limit_ff <= smsnfp_pkg::MESSAGE_LIMIT_RESET;
         stage_ff         <= smsnfp_pkg::ST_WAIT_NUM;
         index_ff         <= '0;
         held_ff[0]       <= '0;
         held_ff[1]       <= '0;
         held_count_ff    <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               smsnfp_pkg::CSR_NUMBER_LIMIT:
                  number_limit_ff <= csr_wdata[smsnfp_pkg::NUM_LIMIT_W-1:0];
               smsnfp_pkg::CSR_MESSAGE_LIMIT:
                  message_limit_ff <= csr_wdata[smsnfp_pkg::MSG_LIMIT_W-1:0];
               default: ;
            endcase
         end
         stage_ff      <= stage_in;
         index_ff      <= index_in;
         held_ff       <= held_in;
         held_count_ff <= held_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // queue payload: the character result goes first, the end result after it
   always_ff @(posedge clock) begin
      if (req_beat) begin
         if (parse_en && char_valid) begin
            queue_ff[wr_ptr_ff] <= char_res;
            if (req_tlast) queue_ff[wr_ptr_next] <= end_res;
         end else if (req_tlast) begin
            queue_ff[wr_ptr_ff] <= end_res;
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smsnfp_pkg::QCNT_W'(smsnfp_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tlast |=> stage_ff == smsnfp_pkg::ST_WAIT_NUM
                                && held_count_ff == 2'd0 && index_ff == '0)
      else $error("parser not cleared after final beat");

   a_hold_depth: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("hold line count out of range");

   a_end_pushed: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tlast |=> rsp_tvalid)
      else $error("end result missing after final beat");

endmodule
